>>> hw/rtl/rmt_pkg.sv
package rmt_pkg;

	localparam int RMT_MAX_ENTRIES = 16;
	localparam int ADDR_W = 32;
	localparam int COUNT_OUT_W = 5;

	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_ADD   = 2'd1,
		ACT_XLATE = 2'd2,
		ACT_CHECK = 2'd3
	} act_t;

	typedef enum logic [2:0] {
		WR_UP,
		WR_DOWN,
		WR_APPEND,
		WR_MERGE,
		WR_MOVE
	} wr_sel_t;

	typedef struct packed {
		logic [ADDR_W-1:0] lb;
		logic [ADDR_W-1:0] pb;
		logic [ADDR_W-1:0] len;
	} entry_t;

	typedef struct packed {
		logic    load;
		logic    ev_scan;
		logic    hold_ent;
		logic    hold_j;
		logic    wr_en;
		wr_sel_t wr_sel;
		logic    rd_en;
		logic    sum_clr;
		logic    sum_add;
		logic    set_drop;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		act_t act;
		logic up_hit;
		logic down_hit;
		logic abs_hit;
		logic tr_hit;
	} sts_t;

endpackage

>>> hw/rtl/rmt_req_if.sv
interface rmt_req_if;
	import rmt_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        action;
	logic [ADDR_W-1:0] logical_address;
	logic [ADDR_W-1:0] physical_address;
	logic [ADDR_W-1:0] region_length;

	modport source (
		output valid, action, logical_address, physical_address, region_length,
		input  ready
	);

	modport sink (
		input  valid, action, logical_address, physical_address, region_length,
		output ready
	);

endinterface

>>> hw/rtl/rmt_rsp_if.sv
interface rmt_rsp_if;
	import rmt_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   found;
	logic [ADDR_W-1:0]      logical_out;
	logic                   same_region;
	logic                   dropped;
	logic [COUNT_OUT_W-1:0] entry_count;
	logic [ADDR_W-1:0]      total_length;

	modport source (
		output valid, found, logical_out, same_region, dropped, entry_count, total_length,
		input  ready
	);

	modport sink (
		input  valid, found, logical_out, same_region, dropped, entry_count, total_length,
		output ready
	);

endinterface

>>> hw/rtl/region_map_table.sv
// Each item makes at most these passes over the table: a search of the
// table, a second search when an add joins an entry to a following one, and a pass
// that sums all lengths, each one entry per cycle through the table's single read port.
// One item is in work at a time; a finished result waits in an output register.
// Reset clears the entry count and all control state; the table contents are not reset.
module region_map_table
	import rmt_pkg::*;
#(
	parameter int MAX_ENTRIES = RMT_MAX_ENTRIES
) (
	input logic     clk,
	input logic     arst_n,
	rmt_req_if.sink   req,
	rmt_rsp_if.source rsp
);

	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	cmd_t          cmd;
	sts_t          sts;
	logic [IW-1:0] rd_addr;
	logic [IW-1:0] wr_addr;
	logic [IW-1:0] ev_idx;
	logic [CW-1:0] count;

	rmt_ctrl #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd),
		.rd_addr   (rd_addr),
		.wr_addr   (wr_addr),
		.ev_idx    (ev_idx),
		.count     (count)
	);

	rmt_datapath #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.action           (req.action),
		.logical_address  (req.logical_address),
		.physical_address (req.physical_address),
		.region_length    (req.region_length),
		.cmd              (cmd),
		.rd_addr          (rd_addr),
		.wr_addr          (wr_addr),
		.ev_idx           (ev_idx),
		.count            (count),
		.sts              (sts),
		.found            (rsp.found),
		.logical_out      (rsp.logical_out),
		.same_region      (rsp.same_region),
		.dropped          (rsp.dropped),
		.entry_count      (rsp.entry_count),
		.total_length     (rsp.total_length)
	);

endmodule

>>> hw/rtl/rmt_datapath.sv
module rmt_datapath
	import rmt_pkg::*;
#(
	parameter int MAX_ENTRIES = RMT_MAX_ENTRIES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [1:0]                   action,
	input  logic [ADDR_W-1:0]            logical_address,
	input  logic [ADDR_W-1:0]            physical_address,
	input  logic [ADDR_W-1:0]            region_length,
	input  cmd_t                         cmd,
	input  logic [$clog2(MAX_ENTRIES)-1:0]   rd_addr,
	input  logic [$clog2(MAX_ENTRIES)-1:0]   wr_addr,
	input  logic [$clog2(MAX_ENTRIES)-1:0]   ev_idx,
	input  logic [$clog2(MAX_ENTRIES+1)-1:0] count,
	output sts_t                         sts,
	output logic                         found,
	output logic [ADDR_W-1:0]            logical_out,
	output logic                         same_region,
	output logic                         dropped,
	output logic [COUNT_OUT_W-1:0]       entry_count,
	output logic [ADDR_W-1:0]            total_length
);

	localparam int IW = $clog2(MAX_ENTRIES);

	entry_t            mem [MAX_ENTRIES];
	entry_t            rd_data_q;
	entry_t            ent_q;
	entry_t            wr_data;

	act_t              act_q;
	logic [ADDR_W-1:0] la_q;
	logic [ADDR_W-1:0] pa_q;
	logic [ADDR_W-1:0] len_q;
	logic [ADDR_W-1:0] la_end_q;
	logic [ADDR_W-1:0] pa_end_q;
	logic [ADDR_W-1:0] lenj_q;

	logic              xl_found_q;
	logic [ADDR_W-1:0] xl_addr_q;
	logic              a_found_q;
	logic              b_found_q;
	logic [IW-1:0]     a_idx_q;
	logic [IW-1:0]     b_idx_q;
	logic              dropped_q;
	logic [ADDR_W-1:0] sum_q;
	logic              sat_q;

	logic              rsp_found_q;
	logic [ADDR_W-1:0] rsp_logical_q;
	logic              rsp_same_q;
	logic              rsp_dropped_q;
	logic [COUNT_OUT_W-1:0] rsp_count_q;
	logic [ADDR_W-1:0] rsp_total_q;

	logic [ADDR_W-1:0] rd_pend;
	logic [ADDR_W-1:0] rd_lend;
	logic [ADDR_W-1:0] grown_len;
	logic [ADDR_W-1:0] ent_pend;
	logic [ADDR_W-1:0] ent_lend;
	logic [ADDR_W:0]   sum_nxt;
	logic              a_hit;
	logic              b_hit;
	logic              same_nxt;

	assign rd_pend   = rd_data_q.pb + rd_data_q.len;
	assign rd_lend   = rd_data_q.lb + rd_data_q.len;
	assign grown_len = rd_data_q.len + len_q;
	assign ent_pend  = ent_q.pb + ent_q.len;
	assign ent_lend  = ent_q.lb + ent_q.len;
	assign sum_nxt   = {1'b0, sum_q} + {1'b0, rd_data_q.len};

	assign a_hit = (rd_data_q.lb <= la_q) && (la_q < rd_lend);
	assign b_hit = (rd_data_q.lb <= la_end_q) && (la_end_q < rd_lend);

	assign sts.act      = act_q;
	assign sts.up_hit   = (rd_pend == pa_q) && (rd_lend == la_q);
	assign sts.down_hit = (pa_end_q == rd_data_q.pb) && (la_end_q == rd_data_q.lb);
	assign sts.abs_hit  = (rd_data_q.pb == ent_pend) && (rd_data_q.lb == ent_lend);
	assign sts.tr_hit   = (rd_data_q.pb <= pa_q) && (pa_q < rd_pend);

	assign same_nxt = (act_q == ACT_CHECK) && (a_found_q == b_found_q)
		&& (!a_found_q || (a_idx_q == b_idx_q));

	always_comb begin
		case (cmd.wr_sel)
			WR_UP:     wr_data = '{lb: rd_data_q.lb, pb: rd_data_q.pb, len: grown_len};
			WR_DOWN:   wr_data = '{lb: la_q, pb: pa_q, len: grown_len};
			WR_APPEND: wr_data = '{lb: la_q, pb: pa_q, len: len_q};
			WR_MERGE:  wr_data = '{lb: ent_q.lb, pb: ent_q.pb, len: ent_q.len + lenj_q};
			WR_MOVE:   wr_data = rd_data_q;
			default:   wr_data = rd_data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q    <= act_t'(action);
			la_q     <= logical_address;
			pa_q     <= physical_address;
			len_q    <= region_length;
			la_end_q <= logical_address + region_length;
			pa_end_q <= physical_address + region_length;
		end
		if (cmd.hold_ent) begin
			ent_q <= '{lb: rd_data_q.lb, pb: rd_data_q.pb, len: grown_len};
		end
		if (cmd.hold_j) begin
			lenj_q <= rd_data_q.len;
		end
		if (cmd.ev_scan && act_q == ACT_XLATE && sts.tr_hit && !xl_found_q) begin
			xl_addr_q <= pa_q - rd_data_q.pb + rd_data_q.lb;
		end
		if (cmd.ev_scan && act_q == ACT_CHECK) begin
			if (!a_found_q && a_hit) begin
				a_idx_q <= ev_idx;
			end
			if (!b_found_q && b_hit) begin
				b_idx_q <= ev_idx;
			end
		end
		if (cmd.sum_clr) begin
			sum_q <= '0;
		end else if (cmd.sum_add) begin
			sum_q <= sum_nxt[ADDR_W-1:0];
		end
		if (cmd.out_load) begin
			rsp_found_q   <= xl_found_q;
			rsp_logical_q <= xl_found_q ? xl_addr_q : '0;
			rsp_same_q    <= same_nxt;
			rsp_dropped_q <= dropped_q;
			rsp_count_q   <= COUNT_OUT_W'(count);
			rsp_total_q   <= sat_q ? '1 : sum_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xl_found_q <= 1'b0;
			a_found_q  <= 1'b0;
			b_found_q  <= 1'b0;
			dropped_q  <= 1'b0;
			sat_q      <= 1'b0;
		end else begin
			if (cmd.load) begin
				xl_found_q <= 1'b0;
				a_found_q  <= 1'b0;
				b_found_q  <= 1'b0;
				dropped_q  <= 1'b0;
			end else begin
				if (cmd.ev_scan && act_q == ACT_XLATE && sts.tr_hit) begin
					xl_found_q <= 1'b1;
				end
				if (cmd.ev_scan && act_q == ACT_CHECK) begin
					if (a_hit) begin
						a_found_q <= 1'b1;
					end
					if (b_hit) begin
						b_found_q <= 1'b1;
					end
				end
				if (cmd.set_drop) begin
					dropped_q <= 1'b1;
				end
			end
			if (cmd.sum_clr) begin
				sat_q <= 1'b0;
			end else if (cmd.sum_add && sum_nxt[ADDR_W]) begin
				sat_q <= 1'b1;
			end
		end
	end

	assign found        = rsp_found_q;
	assign logical_out  = rsp_logical_q;
	assign same_region  = rsp_same_q;
	assign dropped      = rsp_dropped_q;
	assign entry_count  = rsp_count_q;
	assign total_length = rsp_total_q;

endmodule

>>> hw/rtl/rmt_ctrl.sv
module rmt_ctrl
	import rmt_pkg::*;
#(
	parameter int MAX_ENTRIES = RMT_MAX_ENTRIES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	input  sts_t                             sts,
	output cmd_t                             cmd,
	output logic [$clog2(MAX_ENTRIES)-1:0]   rd_addr,
	output logic [$clog2(MAX_ENTRIES)-1:0]   wr_addr,
	output logic [$clog2(MAX_ENTRIES)-1:0]   ev_idx,
	output logic [$clog2(MAX_ENTRIES+1)-1:0] count
);

	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISP,
		S_SCAN,
		S_ABS0,
		S_ABS,
		S_MERGE,
		S_LASTRD,
		S_MOVE,
		S_APPEND,
		S_SUM,
		S_SUMRUN,
		S_DONE
	} state_t;

	state_t        state_q;
	state_t        state_nxt;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_nxt;
	logic [IW-1:0] ev_idx_q;
	logic [IW-1:0] ev_idx_nxt;
	logic [IW-1:0] i_q;
	logic [IW-1:0] j_q;
	logic          rsp_valid_q;
	logic [IW-1:0] last_idx;
	logic          at_last;

	assign last_idx = IW'(count_q - CW'(1));
	assign at_last  = (ev_idx_q == last_idx);

	always_comb begin
		cmd        = '0;
		cmd.wr_sel = WR_APPEND;
		state_nxt  = state_q;
		count_nxt  = count_q;
		ev_idx_nxt = ev_idx_q;
		rd_addr    = ev_idx_q + IW'(1);
		wr_addr    = ev_idx_q;
		req_ready  = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_DISP;
				end
			end
			S_DISP: begin
				if (sts.act == ACT_CLEAR) begin
					count_nxt = '0;
					state_nxt = S_SUM;
				end else if (count_q == '0) begin
					state_nxt = (sts.act == ACT_ADD) ? S_APPEND : S_SUM;
				end else begin
					cmd.rd_en  = 1'b1;
					rd_addr    = '0;
					ev_idx_nxt = '0;
					state_nxt  = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.act == ACT_ADD && sts.up_hit) begin
					cmd.wr_en    = 1'b1;
					cmd.wr_sel   = WR_UP;
					cmd.hold_ent = 1'b1;
					state_nxt    = S_ABS0;
				end else if (sts.act == ACT_ADD && sts.down_hit) begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = WR_DOWN;
					state_nxt  = S_SUM;
				end else begin
					cmd.ev_scan = (sts.act != ACT_ADD);
					if (sts.act == ACT_XLATE && sts.tr_hit) begin
						state_nxt = S_SUM;
					end else if (at_last) begin
						state_nxt = (sts.act == ACT_ADD) ? S_APPEND : S_SUM;
					end else begin
						cmd.rd_en  = 1'b1;
						ev_idx_nxt = ev_idx_q + IW'(1);
					end
				end
			end
			S_ABS0: begin
				cmd.rd_en  = 1'b1;
				rd_addr    = '0;
				ev_idx_nxt = '0;
				state_nxt  = S_ABS;
			end
			S_ABS: begin
				if (sts.abs_hit) begin
					cmd.hold_j = 1'b1;
					state_nxt  = S_MERGE;
				end else if (at_last) begin
					state_nxt = S_SUM;
				end else begin
					cmd.rd_en  = 1'b1;
					ev_idx_nxt = ev_idx_q + IW'(1);
				end
			end
			S_MERGE: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_MERGE;
				wr_addr    = i_q;
				state_nxt  = S_LASTRD;
			end
			S_LASTRD: begin
				cmd.rd_en = 1'b1;
				rd_addr   = last_idx;
				state_nxt = S_MOVE;
			end
			S_MOVE: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_MOVE;
				wr_addr    = j_q;
				count_nxt  = count_q - CW'(1);
				state_nxt  = S_SUM;
			end
			S_APPEND: begin
				if (count_q == CW'(MAX_ENTRIES)) begin
					cmd.set_drop = 1'b1;
				end else begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = WR_APPEND;
					wr_addr    = IW'(count_q);
					count_nxt  = count_q + CW'(1);
				end
				state_nxt = S_SUM;
			end
			S_SUM: begin
				cmd.sum_clr = 1'b1;
				if (count_q == '0) begin
					state_nxt = S_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					rd_addr    = '0;
					ev_idx_nxt = '0;
					state_nxt  = S_SUMRUN;
				end
			end
			S_SUMRUN: begin
				cmd.sum_add = 1'b1;
				if (at_last) begin
					state_nxt = S_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					ev_idx_nxt = ev_idx_q + IW'(1);
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			ev_idx_q    <= '0;
			i_q         <= '0;
			j_q         <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_nxt;
			count_q  <= count_nxt;
			ev_idx_q <= ev_idx_nxt;
			if (cmd.hold_ent) begin
				i_q <= ev_idx_q;
			end
			if (cmd.hold_j) begin
				j_q <= ev_idx_q;
			end
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign ev_idx    = ev_idx_q;
	assign count     = count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("entry count above table size");

	a_no_rw_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_en && cmd.rd_en) |-> (wr_addr != rd_addr))
		else $error("table read and write at the same address");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q > $past(count_q)) |-> (count_q == $past(count_q) + CW'(1)))
		else $error("entry count grew by more than one");

	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> (state_q == S_IDLE && rsp_valid_q))
		else $error("result transfer not presented after completion");

endmodule
